// ===== rtl/swm_pkg.sv =====
// shared types and constants of the sliding window median core
`default_nettype none

package swm_pkg;

    localparam int WIN_MAX    = 16;
    localparam int IDX_W      = $clog2(WIN_MAX);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(WIN_MAX);

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]    tag;
    } cell_t;

    typedef struct packed {
        logic accept;
        logic compact;
        logic insert;
        logic rd_hi;
        logic rd_lo;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic dirty;
        logic is_push;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/swm_ctrl.sv =====
// sequencing state machine of the sliding window median core
`default_nettype none

module swm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  swm_pkg::stat_t     stat,
    output swm_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COMPACT = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_RD_HI   = 3'd3;
    localparam logic [2:0] ST_RD_LO   = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_tready = (state_reg == ST_IDLE) && !stat.dirty;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.compact = stat.dirty;
                cmd.accept  = s_tvalid && !stat.dirty;
                if (cmd.accept) begin
                    state_next = ST_COMPACT;
                end
            end
            ST_COMPACT: begin
                if (stat.dirty) begin
                    cmd.compact = 1'b1;
                end else if (stat.is_push) begin
                    state_next = ST_INSERT;
                end else begin
                    state_next = ST_RD_HI;
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RD_LO;
            end
            ST_RD_LO: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swm_datapath.sv =====
// sorted sample row, ring pointers and median output register
`default_nettype none

module swm_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          kind,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [swm_pkg::CNT_W-1:0]     remove_count,
    input  wire logic                          cfg_we,
    input  wire logic [swm_pkg::CNT_W-1:0]     cfg_wdata,
    input  swm_pkg::cmd_t                      cmd,
    output swm_pkg::stat_t                     stat,
    output logic [swm_pkg::SAMPLE_W-1:0]       median,
    output logic [swm_pkg::CNT_W-1:0]          count,
    output logic                               empty_res
);

    localparam int N  = swm_pkg::WIN_MAX;
    localparam int IW = swm_pkg::IDX_W;
    localparam int CW = swm_pkg::CNT_W;
    localparam int SW = swm_pkg::SAMPLE_W;

    swm_pkg::cell_t cells_reg [N];
    swm_pkg::cell_t cells_next [N];

    logic [CW-1:0] sorted_n_reg, sorted_n_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] size_reg, size_next;
    logic          kind_reg;
    logic [SW-1:0] sample_reg;
    logic [SW-1:0] hi_reg, lo_reg;
    logic [SW-1:0] median_reg;
    logic [CW-1:0] count_out_reg;
    logic          empty_reg;

    logic [N-1:0]  shift_dn;
    logic [N-1:0]  pos_ge;
    logic [N-1:0]  in_use;
    logic [N-1:0]  hole;
    logic [N-1:0]  gt;

    logic [CW-1:0] size_clamped;
    logic [CW-1:0] size_diff;
    logic [CW-1:0] drop_amt;
    logic [IW-1:0] new_tag;
    logic [IW-1:0] hi_idx, lo_idx, rd_idx;
    logic [SW-1:0] rd_val;
    logic [SW:0]   pair_sum;
    logic [SW-1:0] median_calc;

    // per-cell status
    for (genvar g = 0; g < N; g++) begin : g_stat
        logic [IW-1:0] rel;
        assign rel      = cells_reg[g].tag - head_reg;
        assign in_use[g] = CW'(g) < sorted_n_reg;
        assign hole[g]   = in_use[g] && ({1'b0, rel} >= count_reg);
        assign gt[g]     = !in_use[g] || (cells_reg[g].value > sample_reg);
    end

    always_comb begin
        logic hole_seen;
        logic gt_seen;
        hole_seen = 1'b0;
        gt_seen   = 1'b0;
        for (int i = 0; i < N; i++) begin
            hole_seen   = hole_seen | hole[i];
            gt_seen     = gt_seen | gt[i];
            shift_dn[i] = hole_seen;
            pos_ge[i]   = gt_seen;
        end
    end

    assign new_tag = head_reg + count_reg[IW-1:0];

    // row of cells: shift down over a hole, or open a slot for a new sample
    always_comb begin
        cells_next = cells_reg;
        for (int i = 0; i < N; i++) begin
            if (cmd.compact && shift_dn[i]) begin
                if (i < N - 1) begin
                    cells_next[i] = cells_reg[(i < N - 1) ? i + 1 : i];
                end
            end else if (cmd.insert && pos_ge[i]) begin
                if (i == 0) begin
                    cells_next[i].value = sample_reg;
                    cells_next[i].tag   = new_tag;
                end else if (!pos_ge[(i > 0) ? i - 1 : i]) begin
                    cells_next[i].value = sample_reg;
                    cells_next[i].tag   = new_tag;
                end else begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : i];
                end
            end
        end
    end

    // oldest-sample drop amount from a size write or an accepted transaction, and next size, head and counts
    always_comb begin
        if (cfg_wdata == '0) begin
            size_clamped = CW'(1);
        end else if (cfg_wdata > CW'(N)) begin
            size_clamped = CW'(N);
        end else begin
            size_clamped = cfg_wdata;
        end
        size_diff = size_reg - size_clamped;
        drop_amt  = '0;
        size_next = size_reg;
        if (cfg_we) begin
            size_next = size_clamped;
            if (size_clamped < size_reg) begin
                drop_amt = (size_diff > count_reg) ? count_reg : size_diff;
            end
        end else if (cmd.accept) begin
            if (kind == swm_pkg::KIND_PUSH) begin
                drop_amt = (count_reg == size_reg) ? CW'(1) : '0;
            end else begin
                drop_amt = (remove_count > count_reg) ? count_reg : remove_count;
            end
        end
        head_next     = head_reg + drop_amt[IW-1:0];
        count_next    = count_reg - drop_amt + CW'(cmd.insert);
        sorted_n_next = sorted_n_reg - CW'(cmd.compact) + CW'(cmd.insert);
    end

    assign stat.dirty   = sorted_n_reg != count_reg;
    assign stat.is_push = kind_reg == swm_pkg::KIND_PUSH;

    // middle element read
    assign hi_idx = count_reg[CW-1:1];
    assign lo_idx = count_reg[0] ? hi_idx : hi_idx - IW'(1);
    assign rd_idx = cmd.rd_hi ? hi_idx : lo_idx;
    assign rd_val = cells_reg[rd_idx].value;

    assign pair_sum = {1'b0, hi_reg} + {1'b0, lo_reg};

    always_comb begin
        if (count_reg == '0) begin
            median_calc = '0;
        end else if (count_reg[0]) begin
            median_calc = hi_reg;
        end else begin
            median_calc = pair_sum[SW:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sorted_n_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            size_reg     <= swm_pkg::SIZE_RESET;
        end else begin
            sorted_n_reg <= sorted_n_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            size_reg     <= size_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.accept) begin
            kind_reg   <= kind;
            sample_reg <= sample;
        end
        if (cmd.rd_hi) begin
            hi_reg <= rd_val;
        end
        if (cmd.rd_lo) begin
            lo_reg <= rd_val;
        end
        if (cmd.load_out) begin
            median_reg    <= median_calc;
            count_out_reg <= count_reg;
            empty_reg     <= count_reg == '0;
        end
    end

    assign median    = median_reg;
    assign count     = count_out_reg;
    assign empty_res = empty_reg;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_core.sv =====
// top level of the sliding window median core
//
// input stream s_*: one transaction per item; s_tuser is the kind
// (0 push s_tdata sample, 1 drop the s_tdata remove_count oldest samples).
// output stream m_*: one transaction per input item carrying the median of
// the window after that item, the sample count, and m_tuser set when empty.
// cfg_we/cfg_wdata write the window size (0 acts as 1, above 16 as 16);
// shrinking drops the oldest samples.
// samples are kept in a sorted row of cells tagged with their ring slot.
// an item passes through compact (one hole squeezed out of the sorted row per
// cycle for each sample it drops), insert (push only), read high, read low and
// finish, which loads the result once the output register is free; the next
// item is accepted after the result is loaded; a shrinking size write keeps
// s_tready low until the samples it drops are squeezed out of the row.
// reset empties the window and sets the size to 16.
// results sit in an output register: the next item is accepted while a
// result waits, and a stalled receiver holds the following result back.
`default_nettype none

module sliding_window_median_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [swm_pkg::S_TDATA_W-1:0]    s_tdata,  // sample, remove_count, pad
    input  wire logic                             s_tuser,  // kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]         m_tdata,  // median, count, pad
    output logic                                  m_tuser,  // empty_res
    input  wire logic                             cfg_we,
    input  wire logic [swm_pkg::CNT_W-1:0]        cfg_wdata
);

    localparam int SW = swm_pkg::SAMPLE_W;
    localparam int CW = swm_pkg::CNT_W;

    swm_pkg::cmd_t  cmd;
    swm_pkg::stat_t stat;

    logic [SW-1:0] median;
    logic [CW-1:0] count;
    logic          empty_res;

    swm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .kind         (s_tuser),
        .sample       (s_tdata[SW-1:0]),
        .remove_count (s_tdata[SW+CW-1:SW]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .median       (median),
        .count        (count),
        .empty_res    (empty_res)
    );

    assign m_tdata = {{(swm_pkg::M_TDATA_W - SW - CW){1'b0}}, count, median};
    assign m_tuser = empty_res;

endmodule

`default_nettype wire
